>>> sv/mfek_pkg.sv
// Shared constants and a helper function of the max-flow core.
package mfek_pkg;

    localparam int VERT      = 32;
    localparam int VBITS     = $clog2(VERT);
    localparam int CNT_BITS  = VBITS + 1;
    localparam int ADDR_BITS = 2 * VBITS;
    localparam int DEPTH     = VERT * VERT;
    localparam int CAP_BITS  = 16;
    localparam int RES_BITS  = CAP_BITS + 1;
    localparam int FLOW_BITS = 21;

    localparam logic [CAP_BITS-1:0]  CAP_ALL_ONES   = '1;
    localparam logic [RES_BITS-1:0]  RES_INF        = '1;
    localparam logic [RES_BITS-1:0]  RES_MAX_FINITE = RES_INF - 1'b1;
    localparam logic [FLOW_BITS-1:0] FLOW_ALL_ONES  = '1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_VERTEX_COUNT  = 2'd0;
    localparam logic [1:0] CFG_SOURCE_VERTEX = 2'd1;
    localparam logic [1:0] CFG_SINK_VERTEX   = 2'd2;

    // Input operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RUN   = 1'b1;

    // Residual value of a stored capacity: all ones means unlimited.
    function automatic logic [RES_BITS-1:0] cap_to_res(input logic [CAP_BITS-1:0] c);
        logic [RES_BITS-1:0] r;
        begin
            if (c == CAP_ALL_ONES)
                r = RES_INF;
            else
                r = {1'b0, c};
            return r;
        end
    endfunction

endpackage

>>> sv/mfek_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mfek_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; a read of the entry being written returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/max_flow_edmonds_karp_core.sv
// Max-flow core: clears and loads a capacity matrix, then runs Edmonds-Karp searches in RAM.
//
// After reset the core clears the capacity memory with busy high.
// A capacity write leaves busy low, so writes may come every cycle while the core is idle.
// A run copies the matrix into the residual memory, then repeats searches:
// each search scans one matrix row per dequeued vertex, one entry at a time through the
// single read port of the residual memory; each augmenting path is walked once to find the
// bottleneck and once more to update forward and reverse residuals. The run ends with one
// result per vertex in use on consecutive cycles, marked by result_strobe; the receiver
// cannot stall them. Busy is high throughout a run, and configuration writes are meant for
// idle periods only.
module max_flow_edmonds_karp_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           op,
    input  logic [4:0]                     from_vertex,
    input  logic [4:0]                     to_vertex,
    input  logic [15:0]                    capacity,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [5:0]                     cfg_data,
    output logic                           result_strobe,
    output logic [4:0]                     vertex,
    output logic                           source_side,
    output logic [20:0]                    max_flow,
    output logic                           last
);

    localparam int VB = mfek_pkg::VBITS;
    localparam int CB = mfek_pkg::CNT_BITS;
    localparam int AB = mfek_pkg::ADDR_BITS;
    localparam int RB = mfek_pkg::RES_BITS;
    localparam int FB = mfek_pkg::FLOW_BITS;
    localparam int KB = AB + 1;
    localparam int V  = mfek_pkg::VERT;
    localparam logic [KB-1:0] DEPTH_K = KB'(mfek_pkg::DEPTH);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_COPY  = 4'd2;
    localparam logic [3:0] S_BINIT = 4'd3;
    localparam logic [3:0] S_POP   = 4'd4;
    localparam logic [3:0] S_SRD   = 4'd5;
    localparam logic [3:0] S_SEV   = 4'd6;
    localparam logic [3:0] S_BRD   = 4'd7;
    localparam logic [3:0] S_BEV   = 4'd8;
    localparam logic [3:0] S_BCHK  = 4'd9;
    localparam logic [3:0] S_URD   = 4'd10;
    localparam logic [3:0] S_UFW   = 4'd11;
    localparam logic [3:0] S_UBW   = 4'd12;
    localparam logic [3:0] S_UCHK  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0]    state_reg, state_next;
    logic [KB-1:0] cnt_reg, cnt_next;
    logic [CB-1:0] head_reg, head_next, tail_reg, tail_next, guard_reg, guard_next;
    logic [CB-1:0] n_reg, n_next, vc_reg, vc_next;
    logic [VB-1:0] s_reg, s_next, t_reg, t_next, src_reg, src_next, snk_reg, snk_next;
    logic [VB-1:0] cur_reg, cur_next, nx_reg, nx_next, v_reg, v_next, u_reg, u_next;
    logic [RB-1:0] bn_reg, bn_next;
    logic [FB-1:0] flow_reg, flow_next;
    logic [V-1:0]  visited_reg, visited_next;
    logic [VB-1:0] parent_reg [V];
    logic [VB-1:0] queue_reg [V];

    logic          par_we, q_we;
    logic [VB-1:0] par_idx, par_val, q_idx, q_val;

    logic          cap_we, res_we;
    logic [AB-1:0] cap_waddr, cap_raddr, res_waddr, res_raddr;
    logic [15:0]   cap_wdata, cap_rdata;
    logic [RB-1:0] res_wdata, res_rdata;

    logic [CB-1:0] n_run;
    logic [RB:0]   bw_sum;
    logic [FB:0]   flow_sum;
    logic          walk_on;

    mfek_ram #(.WIDTH(mfek_pkg::CAP_BITS), .DEPTH(mfek_pkg::DEPTH)) u_cap_ram (
        .clk   (clk),
        .we    (cap_we),
        .waddr (cap_waddr),
        .wdata (cap_wdata),
        .raddr (cap_raddr),
        .rdata (cap_rdata)
    );

    mfek_ram #(.WIDTH(RB), .DEPTH(mfek_pkg::DEPTH)) u_res_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    // Port outputs decode the registered state.
    assign busy          = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_strobe = (state_reg == S_OUT);
    assign vertex        = cnt_reg[VB-1:0];
    assign source_side   = visited_reg[cnt_reg[VB-1:0]];
    assign max_flow      = flow_reg;
    assign last          = (cnt_reg[CB-1:0] == n_reg - 1'b1);

    // Clamped vertex count, path walk condition and the residual and flow sums.
    always_comb
    begin
        if (vc_reg < CB'(2))
            n_run = CB'(2);
        else if (vc_reg > CB'(V))
            n_run = CB'(V);
        else
            n_run = vc_reg;
    end
    assign walk_on  = (v_reg != s_reg) && (guard_reg < n_reg);
    assign bw_sum   = {1'b0, res_rdata} + {1'b0, bn_reg};
    assign flow_sum = {1'b0, flow_reg} + (FB+1)'(bn_reg);

    // Sequencer: next state and memory accesses.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        guard_next   = guard_reg;
        n_next       = n_reg;
        vc_next      = vc_reg;
        s_next       = s_reg;
        t_next       = t_reg;
        src_next     = src_reg;
        snk_next     = snk_reg;
        cur_next     = cur_reg;
        nx_next      = nx_reg;
        v_next       = v_reg;
        u_next       = u_reg;
        bn_next      = bn_reg;
        flow_next    = flow_reg;
        visited_next = visited_reg;
        par_we       = 1'b0;
        par_idx      = v_reg;
        par_val      = cur_reg;
        q_we         = 1'b0;
        q_idx        = tail_reg[VB-1:0];
        q_val        = nx_reg;
        cap_we       = 1'b0;
        cap_waddr    = cnt_reg[AB-1:0];
        cap_wdata    = '0;
        cap_raddr    = cnt_reg[AB-1:0];
        res_we       = 1'b0;
        res_waddr    = {u_reg, v_reg};
        res_wdata    = res_rdata;
        res_raddr    = {cur_reg, nx_reg};

        // Configuration transfers.
        if (cfg_valid)
        begin
            case (cfg_index)
                mfek_pkg::CFG_VERTEX_COUNT:  vc_next  = cfg_data;
                mfek_pkg::CFG_SOURCE_VERTEX: src_next = cfg_data[VB-1:0];
                mfek_pkg::CFG_SINK_VERTEX:   snk_next = cfg_data[VB-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                cap_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DEPTH_K - 1'b1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (op == mfek_pkg::OP_WRITE)
                    begin
                        cap_we    = 1'b1;
                        cap_waddr = {from_vertex, to_vertex};
                        cap_wdata = capacity;
                    end
                    else
                    begin
                        n_next       = n_run;
                        s_next       = src_reg;
                        t_next       = snk_reg;
                        flow_next    = '0;
                        visited_next = '0;
                        cnt_next     = '0;
                        if ((CB'(src_reg) < n_run) && (CB'(snk_reg) < n_run))
                            state_next = S_COPY;
                        else
                            state_next = S_OUT;
                    end
                end
            end
            S_COPY:
            begin
                // Read entry k while writing the converted entry k-1.
                res_we    = (cnt_reg != '0);
                res_waddr = AB'(cnt_reg - 1'b1);
                res_wdata = mfek_pkg::cap_to_res(cap_rdata);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == DEPTH_K)
                    state_next = S_BINIT;
            end
            S_BINIT:
            begin
                visited_next        = '0;
                visited_next[s_reg] = 1'b1;
                par_we              = 1'b1;
                par_idx             = s_reg;
                par_val             = s_reg;
                q_we                = 1'b1;
                q_idx               = '0;
                q_val               = s_reg;
                head_next           = '0;
                tail_next           = CB'(1);
                state_next          = S_POP;
            end
            S_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    cur_next   = queue_reg[head_reg[VB-1:0]];
                    head_next  = head_reg + 1'b1;
                    nx_next    = '0;
                    state_next = S_SRD;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_SRD:
            begin
                state_next = S_SEV;
            end
            S_SEV:
            begin
                if (!visited_reg[nx_reg] && (res_rdata != '0))
                begin
                    visited_next[nx_reg] = 1'b1;
                    par_we               = 1'b1;
                    par_idx              = nx_reg;
                    par_val              = cur_reg;
                    if (nx_reg == t_reg)
                    begin
                        v_next     = t_reg;
                        guard_next = '0;
                        bn_next    = mfek_pkg::RES_INF;
                        state_next = S_BRD;
                    end
                    else if (tail_reg < CB'(V))
                    begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + 1'b1;
                    end
                end
                if (state_next != S_BRD)
                begin
                    if (CB'(nx_reg) == n_reg - 1'b1)
                        state_next = S_POP;
                    else
                    begin
                        nx_next    = nx_reg + 1'b1;
                        state_next = S_SRD;
                    end
                end
            end
            S_BRD:
            begin
                if (walk_on)
                begin
                    u_next     = parent_reg[v_reg];
                    res_raddr  = {parent_reg[v_reg], v_reg};
                    state_next = S_BEV;
                end
                else
                    state_next = S_BCHK;
            end
            S_BEV:
            begin
                if (res_rdata < bn_reg)
                    bn_next = res_rdata;
                v_next     = u_reg;
                guard_next = guard_reg + 1'b1;
                state_next = S_BRD;
            end
            S_BCHK:
            begin
                if (bn_reg == mfek_pkg::RES_INF)
                begin
                    flow_next  = mfek_pkg::FLOW_ALL_ONES;
                    cnt_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    v_next     = t_reg;
                    guard_next = '0;
                    state_next = S_URD;
                end
            end
            S_URD:
            begin
                if (walk_on)
                begin
                    u_next     = parent_reg[v_reg];
                    res_raddr  = {parent_reg[v_reg], v_reg};
                    state_next = S_UFW;
                end
                else
                    state_next = S_UCHK;
            end
            S_UFW:
            begin
                // Forward residual shrinks; the reverse entry is read meanwhile.
                res_we    = 1'b1;
                res_waddr = {u_reg, v_reg};
                if (res_rdata != mfek_pkg::RES_INF)
                    res_wdata = res_rdata - bn_reg;
                res_raddr  = {v_reg, u_reg};
                state_next = S_UBW;
            end
            S_UBW:
            begin
                // Reverse residual grows, saturating below the unlimited code.
                res_we    = 1'b1;
                res_waddr = {v_reg, u_reg};
                if (res_rdata != mfek_pkg::RES_INF)
                begin
                    if (bw_sum > {1'b0, mfek_pkg::RES_MAX_FINITE})
                        res_wdata = mfek_pkg::RES_MAX_FINITE;
                    else
                        res_wdata = bw_sum[RB-1:0];
                end
                v_next     = u_reg;
                guard_next = guard_reg + 1'b1;
                state_next = S_URD;
            end
            S_UCHK:
            begin
                if (flow_sum >= {1'b0, mfek_pkg::FLOW_ALL_ONES})
                begin
                    flow_next  = mfek_pkg::FLOW_ALL_ONES;
                    cnt_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    flow_next  = flow_sum[FB-1:0];
                    state_next = S_BINIT;
                end
            end
            S_OUT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            guard_reg   <= '0;
            n_reg       <= CB'(2);
            vc_reg      <= CB'(V);
            src_reg     <= '0;
            snk_reg     <= VB'(V - 1);
            visited_reg <= '0;
            flow_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            guard_reg   <= guard_next;
            n_reg       <= n_next;
            vc_reg      <= vc_next;
            src_reg     <= src_next;
            snk_reg     <= snk_next;
            visited_reg <= visited_next;
            flow_reg    <= flow_next;
        end
    end

    // Datapath registers, parent links and search queue.
    always_ff @(posedge clk)
    begin
        s_reg   <= s_next;
        t_reg   <= t_next;
        cur_reg <= cur_next;
        nx_reg  <= nx_next;
        v_reg   <= v_next;
        u_reg   <= u_next;
        bn_reg  <= bn_next;
        if (par_we)
            parent_reg[par_idx] <= par_val;
        if (q_we)
            queue_reg[q_idx] <= q_val;
    end

endmodule

>>> sv/mfek_checker.sv
// Port-level checker for the max-flow core, bound to the top level.
module mfek_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_strobe,
    input logic [4:0]  vertex,
    input logic [20:0] max_flow,
    input logic        last
);

    // Results only appear while a run is in progress.
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result transfer outside a run");

    // Results of a run come for consecutive vertices with the same flow.
    a_vertex_step: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last) |=>
        (result_strobe && (vertex == $past(vertex) + 5'd1) && $stable(max_flow)))
        else $error("result sequence broken");

    // The first result of a run reports vertex zero.
    a_first_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_strobe) |-> (vertex == 5'd0))
        else $error("run does not start at vertex zero");

    // The core is idle right after the last result.
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |=> (!busy && !result_strobe))
        else $error("core still busy after last result");

    // An idle core stays idle until an item transfer.
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !busy)
        else $error("core left idle without a transfer");

endmodule

bind max_flow_edmonds_karp_core mfek_checker u_mfek_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .vertex        (vertex),
    .max_flow      (max_flow),
    .last          (last)
);
